// ----- hw/rtl/text_console_cursor_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Concurrent assertion forms used by the cursor engine datapath.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCCE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console cursor engine: check failed");

// Next-cycle implication, disabled during reset.
`define TCCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console cursor engine: check failed");

`endif

// ----- hw/rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Widths, character codes, event kinds, state and the control interface.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int COORD_W = 8;
   localparam int WORK_W  = COORD_W + 1;
   localparam int CHAR_W  = 8;
   localparam int CNT_W   = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [COORD_W-1:0] COLS_RESET = 8'd80;
   localparam logic [COORD_W-1:0] ROWS_RESET = 8'd25;
   localparam logic [CNT_W-1:0]   TAB_STOP   = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_BS         = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LAST = 8'h7F;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 1'b1;

   typedef enum logic [1:0] {
      EV_GLYPH  = 2'd0,
      EV_SCROLL = 2'd1,
      EV_CLEAR  = 2'd2,
      EV_CURSOR = 2'd3
   } event_kind_type;

   typedef enum logic {
      OP_PUT   = 1'b0,
      OP_CLEAR = 1'b1
   } operation_type;

   typedef enum logic [2:0] {
      CLS_BS,
      CLS_TAB,
      CLS_LF,
      CLS_CR,
      CLS_PRINT,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DECODE,
      ST_PUT,
      ST_TAB,
      ST_WRAP,
      ST_SCROLL,
      ST_CURSOR
   } state_type;

   typedef struct packed {
      logic           load;
      logic           clear_home;
      logic           dec_x;
      logic           inc_x;
      logic           tab_step;
      logic           line_feed;
      logic           carriage;
      logic           wrap;
      logic           scroll_fix;
      logic           emit;
      event_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic           slot_free;
      operation_type  req_op;
      char_class_type cls;
      logic           x_zero;
      logic           tab_done;
      logic           x_past;
      logic           y_past;
   } status_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] ch);
      char_class_type cls;
      priority if (ch == CHAR_BS) begin
         cls = CLS_BS;
      end else if (ch == CHAR_TAB) begin
         cls = CLS_TAB;
      end else if (ch == CHAR_LF) begin
         cls = CLS_LF;
      end else if (ch == CHAR_CR) begin
         cls = CLS_CR;
      end else if (ch >= CHAR_SPACE && ch <= CHAR_PRINT_LAST) begin
         cls = CLS_PRINT;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

// ----- hw/rtl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine controller
// Sequences one request through clear or decode, glyph writes, wrap, scroll and cursor.
// ----------------------------------------------------------------------------
module tcce_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcce_pkg::status_type status,
   output tcce_pkg::cmd_type   cmd
);

   tcce_pkg::state_type state_ff;
   tcce_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcce_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcce_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.req_op == tcce_pkg::OP_CLEAR) ?
                          tcce_pkg::ST_CLEAR : tcce_pkg::ST_DECODE;
            end
         end
         tcce_pkg::ST_CLEAR: begin
            if (status.slot_free) begin
               state_in = tcce_pkg::ST_CURSOR;
            end
         end
         tcce_pkg::ST_DECODE: begin
            unique case (status.cls)
               tcce_pkg::CLS_BS:    state_in = status.x_zero ? tcce_pkg::ST_WRAP
                                                             : tcce_pkg::ST_PUT;
               tcce_pkg::CLS_TAB:   state_in = tcce_pkg::ST_TAB;
               tcce_pkg::CLS_PRINT: state_in = tcce_pkg::ST_PUT;
               default:             state_in = tcce_pkg::ST_WRAP;
            endcase
         end
         tcce_pkg::ST_PUT: begin
            if (status.slot_free) begin
               state_in = tcce_pkg::ST_WRAP;
            end
         end
         tcce_pkg::ST_TAB: begin
            if (status.slot_free && status.tab_done) begin
               state_in = tcce_pkg::ST_WRAP;
            end
         end
         tcce_pkg::ST_WRAP: begin
            state_in = tcce_pkg::ST_SCROLL;
         end
         tcce_pkg::ST_SCROLL: begin
            if (!status.y_past || status.slot_free) begin
               state_in = tcce_pkg::ST_CURSOR;
            end
         end
         tcce_pkg::ST_CURSOR: begin
            if (status.slot_free) begin
               state_in = tcce_pkg::ST_IDLE;
            end
         end
         default: state_in = tcce_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = tcce_pkg::EV_GLYPH;
      req_ready = 1'b0;
      unique case (state_ff)
         tcce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tcce_pkg::ST_CLEAR: begin
            cmd.emit       = status.slot_free;
            cmd.kind       = tcce_pkg::EV_CLEAR;
            cmd.clear_home = status.slot_free;
         end
         tcce_pkg::ST_DECODE: begin
            cmd.dec_x     = (status.cls == tcce_pkg::CLS_BS) && !status.x_zero;
            cmd.line_feed = (status.cls == tcce_pkg::CLS_LF);
            cmd.carriage  = (status.cls == tcce_pkg::CLS_CR);
         end
         tcce_pkg::ST_PUT: begin
            cmd.emit  = status.slot_free;
            cmd.kind  = tcce_pkg::EV_GLYPH;
            cmd.inc_x = status.slot_free && (status.cls != tcce_pkg::CLS_BS);
         end
         tcce_pkg::ST_TAB: begin
            cmd.emit     = status.slot_free;
            cmd.kind     = tcce_pkg::EV_GLYPH;
            cmd.tab_step = status.slot_free;
         end
         tcce_pkg::ST_WRAP: begin
            cmd.wrap = status.x_past;
         end
         tcce_pkg::ST_SCROLL: begin
            cmd.emit       = status.y_past && status.slot_free;
            cmd.kind       = tcce_pkg::EV_SCROLL;
            cmd.scroll_fix = status.y_past && status.slot_free;
         end
         tcce_pkg::ST_CURSOR: begin
            cmd.emit = status.slot_free;
            cmd.kind = tcce_pkg::EV_CURSOR;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tcce_dpath.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine datapath
// Geometry registers, cursor and tab counters, and the result register.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_defines.svh"

module tcce_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]          req_char_code,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcce_pkg::COORD_W-1:0]         csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_event_kind,
   output logic [tcce_pkg::CHAR_W-1:0]          rsp_glyph,
   output logic [tcce_pkg::COORD_W-1:0]         rsp_column,
   output logic [tcce_pkg::COORD_W-1:0]         rsp_row,
   output logic                                 rsp_last,
   input  tcce_pkg::cmd_type                    cmd,
   output tcce_pkg::status_type                 status
);

   logic [tcce_pkg::COORD_W-1:0] cols_ff;
   logic [tcce_pkg::COORD_W-1:0] rows_ff;
   logic [tcce_pkg::WORK_W-1:0]  x_ff;
   logic [tcce_pkg::WORK_W-1:0]  x_in;
   logic [tcce_pkg::WORK_W-1:0]  y_ff;
   logic [tcce_pkg::WORK_W-1:0]  y_in;
   logic [tcce_pkg::CNT_W-1:0]   count_ff;
   logic [tcce_pkg::CHAR_W-1:0]  char_ff;

   logic                          rsp_valid_ff;
   tcce_pkg::event_kind_type      rsp_kind_ff;
   logic [tcce_pkg::CHAR_W-1:0]   rsp_glyph_ff;
   logic [tcce_pkg::COORD_W-1:0]  rsp_column_ff;
   logic [tcce_pkg::COORD_W-1:0]  rsp_row_ff;
   logic                          rsp_last_ff;

   logic [tcce_pkg::COORD_W-1:0]  cols_eff;
   logic [tcce_pkg::COORD_W-1:0]  rows_eff;
   logic [tcce_pkg::WORK_W:0]     x_next;
   tcce_pkg::char_class_type      cls;
   logic                          blank;

   logic                          cursor_emit;
   logic                          cursor_on_screen;
   logic                          rsp_other;

   assign cols_eff = (cols_ff == '0) ? tcce_pkg::COORD_W'(1) : cols_ff;
   assign rows_eff = (rows_ff == '0) ? tcce_pkg::COORD_W'(1) : rows_ff;
   assign x_next   = {1'b0, x_ff} + (tcce_pkg::WORK_W + 1)'(1);
   assign cls      = tcce_pkg::classify(char_ff);
   assign blank    = (cls == tcce_pkg::CLS_BS) || (cls == tcce_pkg::CLS_TAB);

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= tcce_pkg::COLS_RESET;
         rows_ff <= tcce_pkg::ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcce_pkg::CSR_COLUMNS: cols_ff <= csr_data;
            tcce_pkg::CSR_ROWS:    rows_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      priority if (cmd.clear_home || cmd.line_feed || cmd.carriage || cmd.wrap) begin
         x_in = '0;
      end else if (cmd.dec_x) begin
         x_in = x_ff - tcce_pkg::WORK_W'(1);
      end else if (cmd.inc_x || cmd.tab_step) begin
         x_in = x_next[tcce_pkg::WORK_W-1:0];
      end else begin
         x_in = x_ff;
      end
      priority if (cmd.clear_home) begin
         y_in = '0;
      end else if (cmd.line_feed || cmd.wrap) begin
         y_in = y_ff + tcce_pkg::WORK_W'(1);
      end else if (cmd.scroll_fix) begin
         y_in = {1'b0, rows_eff - tcce_pkg::COORD_W'(1)};
      end else begin
         y_in = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff  <= req_char_code;
         count_ff <= tcce_pkg::TAB_STOP - {1'b0, x_ff[2:0]};
      end else if (cmd.tab_step) begin
         count_ff <= count_ff - tcce_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.kind;
         rsp_last_ff <= (cmd.kind == tcce_pkg::EV_CURSOR);
         unique case (cmd.kind)
            tcce_pkg::EV_GLYPH: begin
               rsp_glyph_ff  <= blank ? tcce_pkg::CHAR_SPACE : char_ff;
               rsp_column_ff <= x_ff[tcce_pkg::COORD_W-1:0];
               rsp_row_ff    <= y_ff[tcce_pkg::COORD_W-1:0];
            end
            tcce_pkg::EV_CURSOR: begin
               rsp_glyph_ff  <= '0;
               rsp_column_ff <= x_ff[tcce_pkg::COORD_W-1:0];
               rsp_row_ff    <= y_ff[tcce_pkg::COORD_W-1:0];
            end
            default: begin
               rsp_glyph_ff  <= '0;
               rsp_column_ff <= '0;
               rsp_row_ff    <= '0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_glyph      = rsp_glyph_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      status.slot_free = !rsp_valid_ff || rsp_ready;
      status.req_op    = tcce_pkg::operation_type'(req_operation);
      status.cls       = cls;
      status.x_zero    = (x_ff == '0);
      status.tab_done  = (count_ff == tcce_pkg::CNT_W'(1)) ||
                         (x_next >= {2'b00, cols_eff});
      status.x_past    = (x_ff >= {1'b0, cols_eff});
      status.y_past    = (y_ff >= {1'b0, rows_eff});
   end

   assign cursor_emit      = cmd.emit && (cmd.kind == tcce_pkg::EV_CURSOR);
   assign cursor_on_screen = (x_ff < {1'b0, cols_eff}) && (y_ff < {1'b0, rows_eff});
   assign rsp_other        = rsp_valid_ff && (rsp_kind_ff != tcce_pkg::EV_GLYPH);

   `TCCE_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, status.slot_free)
   `TCCE_ASSERT_SAME(a_cursor_on_screen, clock, reset, cursor_emit, cursor_on_screen)
   `TCCE_ASSERT_NEXT(a_cursor_is_last, clock, reset, cursor_emit, rsp_valid_ff && rsp_last_ff)
   `TCCE_ASSERT_SAME(a_glyph_only_on_write, clock, reset, rsp_other, rsp_glyph_ff == '0)

endmodule

// ----- hw/rtl/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns console requests into glyph, scroll, clear and cursor events.
// ----------------------------------------------------------------------------
// Each request is taken while the controller is idle and produces its results
// through a single output register, ending with a cursor event that has last
// set; each event waits until that register is free. A clear emits a clear
// event and then the cursor. Other bytes go through decode; a written byte or
// a backspace that blanks a cell writes one glyph, a tab writes spaces up to
// the next tab stop or the right edge, and an ignored byte, newline, carriage
// return or backspace at column zero write nothing. Wrap, scroll (an event
// only when the row is past the bottom) and the cursor follow. Geometry writes
// are always accepted and must only be made while the engine is idle.
module text_console_cursor_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]          req_char_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_event_kind,
   output logic [tcce_pkg::CHAR_W-1:0]          rsp_glyph,
   output logic [tcce_pkg::COORD_W-1:0]         rsp_column,
   output logic [tcce_pkg::COORD_W-1:0]         rsp_row,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcce_pkg::COORD_W-1:0]         csr_data
);

   tcce_pkg::cmd_type    cmd;
   tcce_pkg::status_type status;

   assign csr_ready = 1'b1;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_glyph      (rsp_glyph),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
